FILE: design/multi_alarm_table_assert.svh
// ----------------------------------------------------------------------------
// multi_alarm_table assertion macros
// Shared property shapes for the alarm table checks.
// ----------------------------------------------------------------------------
`ifndef MULTI_ALARM_TABLE_ASSERT_SVH
`define MULTI_ALARM_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("multi_alarm_table check failed");

// Next-cycle implication, disabled while reset is asserted
`define MAT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("multi_alarm_table check failed");

`endif

FILE: design/mat_pkg.sv
// ----------------------------------------------------------------------------
// mat_pkg
// Types and constants of the multi-slot alarm table.
// ----------------------------------------------------------------------------
package mat_pkg;

  // Operation codes
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_PUT    = 3'd1,
    OP_ON     = 3'd2,
    OP_OFF    = 3'd3,
    OP_DELETE = 3'd4,
    OP_STOP   = 3'd5,
    OP_GET    = 3'd6,
    OP_CLEAR  = 3'd7
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FORMAT      = 3'd1,
    ST_RINGING     = 3'd2,
    ST_DUPLICATE   = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_NOT_RINGING = 3'd5
  } status_e;

  // Entry state codes reported by get
  localparam logic [1:0] ES_IDLE    = 2'd0;
  localparam logic [1:0] ES_ACTIVE  = 2'd1;
  localparam logic [1:0] ES_WAITING = 2'd2;

  localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
  localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
  localparam logic [4:0] NO_SLOT          = 5'd16;

  // Input beat
  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  slot;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        enable;
    logic [15:0] day_number;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [2:0] status;
    logic [4:0] active_slot;
    logic       any_ringing;
    logic       entry_used;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic       entry_enabled;
    logic [1:0] entry_state;
  } out_t;

  // Stored slot record; the used flag lives in flops next to the RAM
  typedef struct packed {
    logic        enabled;
    logic        ringing;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] last_day;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: design/multi_alarm_table.sv
// ----------------------------------------------------------------------------
// multi_alarm_table
// Alarm slot table: tick, put, on, off, delete, stop, get and clear.
// ----------------------------------------------------------------------------
// Flow: an item walks the table in scan, then passes apply and finish; a stop
//   that silences an alarm walks the table a second time.
// A new item is taken only in idle, once the last one is in the output register;
//   each item walks the entry RAM read port, which visits one slot per cycle.
// Reset: per-slot used flags clear at once; no clearing pass over the RAM.
module multi_alarm_table #(
  parameter int unsigned SLOTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mat_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mat_pkg::out_t out_data_o
);
  import mat_pkg::*;

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LAST = CW'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_APPLY  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  in_t               cmd_q, cmd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     pidx_q, pidx_d;
  logic [SLOTS-1:0]  used_q, used_d;
  entry_t            cap_q, cap_d;
  logic              cap_used_q, cap_used_d;
  logic              dup_q, dup_d;
  logic              found_q, found_d;
  entry_t            best_q, best_d;
  logic [IW-1:0]     bidx_q, bidx_d;
  logic              rescan_q, rescan_d;
  out_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  // RAM ports
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  // Command decode
  op_e               op;
  logic [IW-1:0]     slot_idx;
  logic              in_table;

  // Scan datapath
  logic              rd_used;
  entry_t            rd_ent;
  entry_t            post;
  logic              fire;
  logic              better;
  logic              is_self;
  logic              dup_hit;
  entry_t            put_ent;
  entry_t            edit_ent;
  entry_t            stop_ent;

  assign op       = op_e'(cmd_q.operation);
  assign slot_idx = IW'(cmd_q.slot);
  assign in_table = 32'(cmd_q.slot) < SLOTS;

  mat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ram_re = (state_q == S_SCAN) && (cnt_q != LAST);

  // Per-slot evaluation of the entry returned by the RAM
  always_comb begin
    rd_used = used_q[pidx_q];
    rd_ent  = rd_used ? entry_t'(ram_rdata) : '0;
    fire    = (op == OP_TICK) && rd_used && rd_ent.enabled && !rd_ent.ringing &&
              (cmd_q.day_number > rd_ent.last_day) &&
              (cmd_q.hour == rd_ent.hour) && (cmd_q.minute == rd_ent.minute);
    post = rd_ent;
    if (fire) begin
      post.ringing  = 1'b1;
      post.last_day = cmd_q.day_number;
    end
    // Earliest last day, then earliest time; ties keep the lower slot
    better  = rd_used && post.ringing &&
              (!found_q || ({post.last_day, post.hour, post.minute} <
                            {best_q.last_day, best_q.hour, best_q.minute}));
    is_self = in_table && (pidx_q == slot_idx);
    dup_hit = rd_used && !is_self &&
              (rd_ent.hour == cmd_q.hour) && (rd_ent.minute == cmd_q.minute);
  end

  // Records written back by the edit operations
  always_comb begin
    put_ent          = '0;
    put_ent.enabled  = cmd_q.enable;
    put_ent.hour     = cmd_q.hour;
    put_ent.minute   = cmd_q.minute;
    put_ent.last_day = (cap_used_q && (cap_q.hour == cmd_q.hour) &&
                        (cap_q.minute == cmd_q.minute)) ? cap_q.last_day : '0;
    edit_ent         = cap_q;
    edit_ent.enabled = (op == OP_ON);
    stop_ent         = best_q;
    stop_ent.ringing = 1'b0;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    used_d      = used_q;
    cap_d       = cap_q;
    cap_used_d  = cap_used_q;
    dup_d       = dup_q;
    found_d     = found_q;
    best_d      = best_q;
    bidx_d      = bidx_q;
    rescan_d    = rescan_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = pidx_q;
    ram_wdata   = post;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = in_data_i;
          cnt_d      = '0;
          pend_d     = 1'b0;
          cap_d      = '0;
          cap_used_d = 1'b0;
          dup_d      = 1'b0;
          found_d    = 1'b0;
          rescan_d   = 1'b0;
          state_d    = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read a cycle, process the entry that comes back
        if (cnt_q != LAST) begin
          cnt_d = cnt_q + 1'b1;
        end
        pend_d = (cnt_q != LAST);
        pidx_d = cnt_q[IW-1:0];
        if (pend_q) begin
          if (is_self) begin
            cap_d      = rd_ent;
            cap_used_d = rd_used;
          end
          if (dup_hit) begin
            dup_d = 1'b1;
          end
          if (better) begin
            found_d = 1'b1;
            best_d  = post;
            bidx_d  = pidx_q;
          end
          if (fire) begin
            ram_we = 1'b1;
          end
        end
        if ((cnt_q == LAST) && !pend_q) begin
          state_d = rescan_q ? S_FINISH : S_APPLY;
        end
      end

      S_APPLY: begin
        res_d        = '0;
        res_d.status = ST_OK;
        state_d      = S_FINISH;
        unique case (op)
          OP_TICK: begin
          end
          OP_PUT, OP_ON, OP_OFF, OP_DELETE: begin
            priority if (!in_table) begin
              res_d.status = ST_NOT_FOUND;
            end else if (cap_q.ringing) begin
              res_d.status = ST_RINGING;
            end else if (op == OP_PUT) begin
              priority if ((cmd_q.hour >= HOURS_PER_DAY) ||
                           (cmd_q.minute >= MINUTES_PER_HOUR)) begin
                res_d.status = ST_FORMAT;
              end else if (dup_q) begin
                res_d.status = ST_DUPLICATE;
              end else begin
                ram_we           = 1'b1;
                ram_waddr        = slot_idx;
                ram_wdata        = put_ent;
                used_d[slot_idx] = 1'b1;
              end
            end else if (!cap_used_q) begin
              res_d.status = ST_NOT_FOUND;
            end else if (op == OP_DELETE) begin
              used_d[slot_idx] = 1'b0;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot_idx;
              ram_wdata = edit_ent;
            end
          end
          OP_STOP: begin
            if (!found_q) begin
              res_d.status = ST_NOT_RINGING;
            end else begin
              // Silence the active slot, then walk again for the new active one
              ram_we    = 1'b1;
              ram_waddr = bidx_q;
              ram_wdata = stop_ent;
              cnt_d     = '0;
              pend_d    = 1'b0;
              found_d   = 1'b0;
              rescan_d  = 1'b1;
              state_d   = S_SCAN;
            end
          end
          OP_GET: begin
            if (in_table && cap_used_q) begin
              res_d.entry_used    = 1'b1;
              res_d.entry_hour    = cap_q.hour;
              res_d.entry_minute  = cap_q.minute;
              res_d.entry_enabled = cap_q.enabled;
              priority if (!cap_q.ringing) begin
                res_d.entry_state = ES_IDLE;
              end else if (found_q && (bidx_q == slot_idx)) begin
                res_d.entry_state = ES_ACTIVE;
              end else begin
                res_d.entry_state = ES_WAITING;
              end
            end
          end
          OP_CLEAR: begin
            used_d  = '0;
            found_d = 1'b0;
          end
          default: begin
          end
        endcase
      end

      S_FINISH: begin
        // Wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          out_d             = res_q;
          out_d.active_slot = found_q ? 5'(bidx_q) : NO_SLOT;
          out_d.any_ringing = found_q;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pidx_q      <= '0;
      used_q      <= '0;
      found_q     <= 1'b0;
      rescan_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      pidx_q      <= pidx_d;
      used_q      <= used_d;
      found_q     <= found_d;
      rescan_q    <= rescan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cap_q      <= cap_d;
    cap_used_q <= cap_used_d;
    dup_q      <= dup_d;
    best_q     <= best_d;
    bidx_q     <= bidx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/mat_ram.sv
// ----------------------------------------------------------------------------
// mat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mat_ram #(
  parameter int unsigned WIDTH = 29,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/mat_checker.sv
// ----------------------------------------------------------------------------
// mat_checker
// Port-level checks of the alarm table, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_alarm_table_assert.svh"

module mat_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input mat_pkg::out_t out_data_o
);
  import mat_pkg::*;

  // A stalled output beat holds
  `MAT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Ringing flag agrees with the active slot
  `MAT_ASSERT_IMP(a_ring_flag, clk_i, rst_ni, out_valid_o, out_data_o.any_ringing == (out_data_o.active_slot != NO_SLOT))

  // No entry data without a used entry
  `MAT_ASSERT_IMP(a_entry_zero, clk_i, rst_ni, out_valid_o && !out_data_o.entry_used, (out_data_o.entry_hour == '0) && (out_data_o.entry_minute == '0) && !out_data_o.entry_enabled && (out_data_o.entry_state == ES_IDLE))

  // A ringing entry implies something rings
  `MAT_ASSERT_IMP(a_state_ring, clk_i, rst_ni, out_valid_o && (out_data_o.entry_state != ES_IDLE), out_data_o.any_ringing)

  // One item at a time: busy right after an accepted beat
  `MAT_ASSERT_NXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind multi_alarm_table mat_checker u_mat_checker (.*);
